// ----- rtl/tqf_pkg.sv -----
// ============================================================================
// Triangle quality filter package
// Widths, register indexes and reject codes shared by the filter RTL.
// ============================================================================
package tqf_pkg;

    localparam int INDEX_W   = 16;   // vertex index width
    localparam int VCOUNT_W  = INDEX_W + 1;
    localparam int COORD_W   = 32;   // signed Q16.16 coordinate
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;        // signed product of two diffs
    localparam int ESQ_W     = PROD_W - 1;        // square of a diff, unsigned
    localparam int ESUM_W    = ESQ_W + 1;         // sum of three squares
    localparam int KS_W      = PROD_W + 1;        // signed cross product term
    localparam int KM_W      = PROD_W;            // cross product magnitude
    localparam int HALF_W    = KM_W / 2;          // limb for squaring
    localparam int KSQ_W     = 2 * KM_W;          // squared magnitude
    localparam int N2_W      = KSQ_W + 2;         // sum of three squares
    localparam int AREA_SHR  = 34;                // Q70.64 -> Q68.32 with halving
    localparam int RAD_W     = N2_W - AREA_SHR;   // square root input width
    localparam int ROOT_W    = RAD_W / 2;         // square root result width
    localparam int REM_W     = ROOT_W + 4;        // partial remainder width
    localparam int SQ_STEPS  = ROOT_W;            // one root bit per stage
    localparam int LANES     = 4;                 // area + one lane per edge
    localparam int EDGE_W    = DIFF_W;            // edge length width
    localparam int PER_W     = EDGE_W + 2;        // perimeter width
    localparam int CFG_W     = 32;
    localparam int EPS_W     = 16;
    localparam int AREA_LO_W = CFG_W;
    localparam int AREA_HI_W = ROOT_W - AREA_LO_W;
    localparam int PL_W      = AREA_LO_W + CFG_W;
    localparam int PH_W      = AREA_HI_W + CFG_W;
    localparam int LHS_W     = EDGE_W + PER_W;
    localparam int EPSP_W    = EPS_W + PER_W;
    localparam int RHS_W     = PH_W + AREA_LO_W + 3;
    localparam int TWA_W     = ROOT_W + 17;
    localparam int IN_DATA_W = 3 * INDEX_W + 9 * COORD_W;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [2:0] {
        RC_KEEP    = 3'd0,
        RC_INDEX   = 3'd1,
        RC_REPEAT  = 3'd2,
        RC_DEGEN   = 3'd3,
        RC_SMALL   = 3'd4,
        RC_SHORT   = 3'd5,
        RC_LONG    = 3'd6,
        RC_ASPECT  = 3'd7
    } reject_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VERTEX_COUNT = 3'd0,
        CFG_MIN_AREA     = 3'd1,
        CFG_MAX_EDGE     = 3'd2,
        CFG_MAX_ASPECT   = 3'd3,
        CFG_AREA_EPS     = 3'd4,
        CFG_LENGTH_EPS   = 3'd5
    } cfg_index_t;

endpackage

// ----- rtl/triangle_quality_filter.sv -----
// ============================================================================
// Triangle quality filter
// Rejects bad-index, degenerate, small, short-edged, long-edged or thin
// triangles; reports keep flag, saturated area and reject code per beat.
// ============================================================================
// Throughput: one triangle per cycle unless stalled; the depth is set by the
//   50-stage bit-per-stage square root, which runs the area lane and one
//   lane per edge side by side.
// Stall: the whole pipeline holds while the output register is full and
//   m_tready is low. Reset clears valid bits and the configuration registers.
module triangle_quality_filter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // index_a, index_b, index_c, ax, ay, az, bx, by_coord, bz, cx, cy, cz
    input  logic [tqf_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // keep, tri_area, reject_code, zero pad
    output logic [tqf_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tqf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tqf_pkg::CFG_W-1:0]         cfg_data
);
    import tqf_pkg::*;

    localparam int L = SQ_STEPS - 1;

    logic adv;

    // configuration
    logic [VCOUNT_W-1:0] vcount_reg;
    logic [CFG_W-1:0]    min_area_reg, max_edge_reg, max_aspect_reg;
    logic [EPS_W-1:0]    area_eps_reg, len_eps_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg     <= '0;
            min_area_reg   <= '0;
            max_edge_reg   <= '0;
            max_aspect_reg <= '0;
            area_eps_reg   <= '0;
            len_eps_reg    <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_VERTEX_COUNT: vcount_reg     <= cfg_data[VCOUNT_W-1:0];
                CFG_MIN_AREA:     min_area_reg   <= cfg_data;
                CFG_MAX_EDGE:     max_edge_reg   <= cfg_data;
                CFG_MAX_ASPECT:   max_aspect_reg <= cfg_data;
                CFG_AREA_EPS:     area_eps_reg   <= cfg_data[EPS_W-1:0];
                CFG_LENGTH_EPS:   len_eps_reg    <= cfg_data[EPS_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    logic                      s0_valid_reg;
    logic [INDEX_W-1:0]        s0_idx_reg [3];
    logic signed [COORD_W-1:0] s0_pos_reg [9];

    logic                      s1_valid_reg;
    reject_code_t              s1_code_reg;
    logic signed [DIFF_W-1:0]  s1_u_reg [3], s1_v_reg [3], s1_w_reg [3];

    logic                      s2_valid_reg;
    reject_code_t              s2_code_reg;
    logic signed [PROD_W-1:0]  s2_cp_reg [6];
    logic [ESQ_W-1:0]          s2_esq_reg [9];

    logic                      s3_valid_reg;
    reject_code_t              s3_code_reg;
    logic signed [KS_W-1:0]    s3_k_reg [3];
    logic [ESUM_W-1:0]         s3_esum_reg [3];

    logic                      s4_valid_reg;
    reject_code_t              s4_code_reg;
    logic [KM_W-1:0]           s4_km_reg [3];
    logic [ESUM_W-1:0]         s4_esum_reg [3];

    logic                      s5_valid_reg;
    reject_code_t              s5_code_reg;
    logic [PROD_W-1:0]         s5_hh_reg [3], s5_hl_reg [3], s5_ll_reg [3];
    logic [ESUM_W-1:0]         s5_esum_reg [3];

    logic                      s6_valid_reg;
    reject_code_t              s6_code_reg;
    logic [KSQ_W-1:0]          s6_ksq_reg [3];
    logic [ESUM_W-1:0]         s6_esum_reg [3];

    logic                      s7_valid_reg;
    reject_code_t              s7_code_reg;
    logic [RAD_W-1:0]          s7_rad_reg [LANES];

    logic                      sq_valid_reg [SQ_STEPS];
    reject_code_t              sq_code_reg  [SQ_STEPS];
    logic [RAD_W-1:0]          sq_rad_reg   [SQ_STEPS][LANES];
    logic [REM_W-1:0]          sq_rem_reg   [SQ_STEPS][LANES];
    logic [ROOT_W-1:0]         sq_root_reg  [SQ_STEPS][LANES];

    logic                      a_valid_reg;
    reject_code_t              a_code_reg;
    logic [ROOT_W-1:0]         a_area_reg;
    logic [EDGE_W-1:0]         a_emax_reg;
    logic [PER_W-1:0]          a_per_reg;
    logic                      a_degen_reg, a_small_reg, a_short_reg;
    logic [PL_W-1:0]           a_pl_reg;
    logic [PH_W-1:0]           a_ph_reg;

    logic                      b_valid_reg;
    reject_code_t              b_code_reg;
    logic [ROOT_W-1:0]         b_area_reg;
    logic                      b_degen_reg, b_small_reg, b_short_reg, b_long_reg;
    logic [LHS_W-1:0]          b_lhs_reg;
    logic [EPSP_W-1:0]         b_epsp_reg;
    logic [RHS_W-1:0]          b_rhs_reg;

    logic                      m_valid_reg;
    logic                      out_keep_reg;
    logic [CFG_W-1:0]          out_area_reg;
    reject_code_t              out_code_reg;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, out_code_reg, out_area_reg, out_keep_reg};

    // ------------------------------------------------------------------
    // Next values
    // ------------------------------------------------------------------
    logic [INDEX_W-1:0]        idx_next [3];
    logic signed [COORD_W-1:0] pos_next [9];
    reject_code_t              s1_code_next;
    logic signed [DIFF_W-1:0]  u_next [3], v_next [3], w_next [3];
    logic signed [PROD_W-1:0]  cp_next [6];
    logic signed [PROD_W-1:0]  esq_full [9];
    logic signed [DIFF_W-1:0]  edge_d [9];
    logic [ESQ_W-1:0]          esq_next [9];
    logic signed [KS_W-1:0]    k_next [3];
    logic [ESUM_W-1:0]         esum_next [3];
    logic signed [KS_W-1:0]    kneg [3];
    logic [KM_W-1:0]           km_next [3];
    logic [HALF_W-1:0]         km_hi [3], km_lo [3];
    logic [PROD_W-1:0]         hh_next [3], hl_next [3], ll_next [3];
    logic [KSQ_W-1:0]          ksq_next [3];
    logic [N2_W-1:0]           n2_sum;
    logic [RAD_W-1:0]          rad_next [LANES];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            idx_next[i] = s_tdata[i*INDEX_W +: INDEX_W];
        end
        for (int i = 0; i < 9; i++) begin
            pos_next[i] = s_tdata[3*INDEX_W + i*COORD_W +: COORD_W];
        end
    end

    // Stage 1: differences and index checks
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            u_next[i] = DIFF_W'(s0_pos_reg[3+i]) - DIFF_W'(s0_pos_reg[i]);
            v_next[i] = DIFF_W'(s0_pos_reg[6+i]) - DIFF_W'(s0_pos_reg[i]);
            w_next[i] = DIFF_W'(s0_pos_reg[3+i]) - DIFF_W'(s0_pos_reg[6+i]);
        end
        if ({1'b0, s0_idx_reg[0]} >= vcount_reg || {1'b0, s0_idx_reg[1]} >= vcount_reg
                || {1'b0, s0_idx_reg[2]} >= vcount_reg) begin
            s1_code_next = RC_INDEX;
        end else if (s0_idx_reg[0] == s0_idx_reg[1] || s0_idx_reg[1] == s0_idx_reg[2]
                || s0_idx_reg[0] == s0_idx_reg[2]) begin
            s1_code_next = RC_REPEAT;
        end else begin
            s1_code_next = RC_KEEP;
        end
    end

    // Stage 2: cross product terms and edge squares
    always_comb begin
        cp_next[0] = s1_u_reg[1] * s1_v_reg[2];
        cp_next[1] = s1_u_reg[2] * s1_v_reg[1];
        cp_next[2] = s1_u_reg[2] * s1_v_reg[0];
        cp_next[3] = s1_u_reg[0] * s1_v_reg[2];
        cp_next[4] = s1_u_reg[0] * s1_v_reg[1];
        cp_next[5] = s1_u_reg[1] * s1_v_reg[0];
        for (int i = 0; i < 3; i++) begin
            edge_d[i]   = s1_u_reg[i];
            edge_d[3+i] = s1_w_reg[i];
            edge_d[6+i] = s1_v_reg[i];
        end
        for (int i = 0; i < 9; i++) begin
            esq_full[i] = edge_d[i] * edge_d[i];
            esq_next[i] = esq_full[i][ESQ_W-1:0];
        end
    end

    // Stage 3: cross product and edge square sums
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            k_next[j]    = KS_W'(s2_cp_reg[2*j]) - KS_W'(s2_cp_reg[2*j+1]);
            esum_next[j] = ESUM_W'(s2_esq_reg[3*j]) + ESUM_W'(s2_esq_reg[3*j+1])
                         + ESUM_W'(s2_esq_reg[3*j+2]);
        end
    end

    // Stage 4-6: magnitude, limb products, squared magnitude
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            kneg[j]    = -s3_k_reg[j];
            km_next[j] = s3_k_reg[j][KS_W-1] ? kneg[j][KM_W-1:0] : s3_k_reg[j][KM_W-1:0];
            km_hi[j]   = s4_km_reg[j][KM_W-1:HALF_W];
            km_lo[j]   = s4_km_reg[j][HALF_W-1:0];
            hh_next[j] = km_hi[j] * km_hi[j];
            hl_next[j] = km_hi[j] * km_lo[j];
            ll_next[j] = km_lo[j] * km_lo[j];
            ksq_next[j] = {s5_hh_reg[j], {KM_W{1'b0}}}
                        + (KSQ_W'(s5_hl_reg[j]) << (HALF_W + 1))
                        + KSQ_W'(s5_ll_reg[j]);
        end
    end

    // Stage 7: |K|^2 scaled to the area radicand, edge square sums as edge radicands
    always_comb begin
        n2_sum = N2_W'(s6_ksq_reg[0]) + N2_W'(s6_ksq_reg[1]) + N2_W'(s6_ksq_reg[2]);
        rad_next[0] = n2_sum[N2_W-1:AREA_SHR];
        for (int j = 0; j < 3; j++) begin
            rad_next[j+1] = RAD_W'(s6_esum_reg[j]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end else if (adv) begin
            s0_valid_reg <= s_tvalid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s0_idx_reg  <= idx_next;
            s0_pos_reg  <= pos_next;
            s1_code_reg <= s1_code_next;
            s1_u_reg    <= u_next;
            s1_v_reg    <= v_next;
            s1_w_reg    <= w_next;
            s2_code_reg <= s1_code_reg;
            s2_cp_reg   <= cp_next;
            s2_esq_reg  <= esq_next;
            s3_code_reg <= s2_code_reg;
            s3_k_reg    <= k_next;
            s3_esum_reg <= esum_next;
            s4_code_reg <= s3_code_reg;
            s4_km_reg   <= km_next;
            s4_esum_reg <= s3_esum_reg;
            s5_code_reg <= s4_code_reg;
            s5_hh_reg   <= hh_next;
            s5_hl_reg   <= hl_next;
            s5_ll_reg   <= ll_next;
            s5_esum_reg <= s4_esum_reg;
            s6_code_reg <= s5_code_reg;
            s6_ksq_reg  <= ksq_next;
            s6_esum_reg <= s5_esum_reg;
            s7_code_reg <= s6_code_reg;
            s7_rad_reg  <= rad_next;
        end
    end

    // ------------------------------------------------------------------
    // Square root: one root bit per stage, four lanes side by side
    // ------------------------------------------------------------------
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
        logic              prev_valid;
        reject_code_t      prev_code;
        logic [RAD_W-1:0]  prev_rad  [LANES];
        logic [REM_W-1:0]  prev_rem  [LANES];
        logic [ROOT_W-1:0] prev_root [LANES];
        logic [REM_W-1:0]  rem_sh    [LANES];
        logic [REM_W-1:0]  trial     [LANES];
        logic [RAD_W-1:0]  rad_n     [LANES];
        logic [REM_W-1:0]  rem_n     [LANES];
        logic [ROOT_W-1:0] root_n    [LANES];

        if (k == 0) begin : g_first
            always_comb begin
                prev_valid = s7_valid_reg;
                prev_code  = s7_code_reg;
                for (int j = 0; j < LANES; j++) begin
                    prev_rad[j]  = s7_rad_reg[j];
                    prev_rem[j]  = '0;
                    prev_root[j] = '0;
                end
            end
        end else begin : g_next
            always_comb begin
                prev_valid = sq_valid_reg[k-1];
                prev_code  = sq_code_reg[k-1];
                for (int j = 0; j < LANES; j++) begin
                    prev_rad[j]  = sq_rad_reg[k-1][j];
                    prev_rem[j]  = sq_rem_reg[k-1][j];
                    prev_root[j] = sq_root_reg[k-1][j];
                end
            end
        end

        always_comb begin
            for (int j = 0; j < LANES; j++) begin
                rem_sh[j] = {prev_rem[j][REM_W-3:0], prev_rad[j][RAD_W-1 -: 2]};
                trial[j]  = REM_W'({prev_root[j], 2'b01});
                rad_n[j]  = {prev_rad[j][RAD_W-3:0], 2'b00};
                if (rem_sh[j] >= trial[j]) begin
                    rem_n[j]  = rem_sh[j] - trial[j];
                    root_n[j] = {prev_root[j][ROOT_W-2:0], 1'b1};
                end else begin
                    rem_n[j]  = rem_sh[j];
                    root_n[j] = {prev_root[j][ROOT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_valid_reg[k] <= 1'b0;
            end else if (adv) begin
                sq_valid_reg[k] <= prev_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_code_reg[k] <= prev_code;
                sq_rad_reg[k]  <= rad_n;
                sq_rem_reg[k]  <= rem_n;
                sq_root_reg[k] <= root_n;
            end
        end
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    logic [ROOT_W-1:0]    area_a;
    logic [EDGE_W-1:0]    e_a [3];
    logic [EDGE_W-1:0]    emax_next;
    logic [PER_W-1:0]     per_next;
    logic                 degen_next, small_next, short_next;
    logic [PL_W-1:0]      pl_next;
    logic [PH_W-1:0]      ph_next;
    logic [LHS_W-1:0]     lhs_next;
    logic [EPSP_W-1:0]    epsp_next;
    logic [RHS_W-1:0]     rhs_next;
    logic                 long_next;
    logic [TWA_W-1:0]     twice_a;
    logic                 aspect_fail;
    reject_code_t         out_code_next;

    always_comb begin
        area_a = sq_root_reg[L][0];
        for (int i = 0; i < 3; i++) begin
            e_a[i] = sq_root_reg[L][i+1][EDGE_W-1:0];
        end
        emax_next = e_a[0];
        if (e_a[1] > emax_next) emax_next = e_a[1];
        if (e_a[2] > emax_next) emax_next = e_a[2];
        per_next   = PER_W'(e_a[0]) + PER_W'(e_a[1]) + PER_W'(e_a[2]);
        degen_next = area_a <= ROOT_W'(area_eps_reg);
        small_next = (min_area_reg != '0) && (area_a < ROOT_W'(min_area_reg));
        short_next = (e_a[0] <= EDGE_W'(len_eps_reg)) || (e_a[1] <= EDGE_W'(len_eps_reg))
                  || (e_a[2] <= EDGE_W'(len_eps_reg));
        pl_next = area_a[AREA_LO_W-1:0] * max_aspect_reg;
        ph_next = area_a[ROOT_W-1:AREA_LO_W] * max_aspect_reg;

        lhs_next  = a_emax_reg * a_per_reg;
        epsp_next = len_eps_reg * a_per_reg;
        rhs_next  = ((RHS_W'(a_ph_reg) << AREA_LO_W) + RHS_W'(a_pl_reg)) << 2;
        long_next = (max_edge_reg != '0) && (a_emax_reg > EDGE_W'(max_edge_reg));

        twice_a     = TWA_W'(b_area_reg) << 17;
        aspect_fail = (max_aspect_reg != '0)
                   && ((twice_a <= TWA_W'(b_epsp_reg)) || (RHS_W'(b_lhs_reg) > b_rhs_reg));
        if (b_code_reg != RC_KEEP)  out_code_next = b_code_reg;
        else if (b_degen_reg)       out_code_next = RC_DEGEN;
        else if (b_small_reg)       out_code_next = RC_SMALL;
        else if (b_short_reg)       out_code_next = RC_SHORT;
        else if (b_long_reg)        out_code_next = RC_LONG;
        else if (aspect_fail)       out_code_next = RC_ASPECT;
        else                        out_code_next = RC_KEEP;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= sq_valid_reg[L];
            b_valid_reg <= a_valid_reg;
            m_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_code_reg   <= sq_code_reg[L];
            a_area_reg   <= area_a;
            a_emax_reg   <= emax_next;
            a_per_reg    <= per_next;
            a_degen_reg  <= degen_next;
            a_small_reg  <= small_next;
            a_short_reg  <= short_next;
            a_pl_reg     <= pl_next;
            a_ph_reg     <= ph_next;
            b_code_reg   <= a_code_reg;
            b_area_reg   <= a_area_reg;
            b_degen_reg  <= a_degen_reg;
            b_small_reg  <= a_small_reg;
            b_short_reg  <= a_short_reg;
            b_long_reg   <= long_next;
            b_lhs_reg    <= lhs_next;
            b_epsp_reg   <= epsp_next;
            b_rhs_reg    <= rhs_next;
            out_code_reg <= out_code_next;
            out_keep_reg <= out_code_next == RC_KEEP;
            // saturate the area to 32 bits
            out_area_reg <= (b_area_reg[ROOT_W-1:CFG_W] != '0) ? '1
                                                               : b_area_reg[CFG_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_keep_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_keep_reg == (out_code_reg == RC_KEEP)))
        else $error("keep flag disagrees with reject code");

    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> s0_valid_reg)
        else $error("accepted beat did not enter the pipeline");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |-> !s_tready)
        else $error("input taken while the pipeline is stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg)
        else $error("output valid after reset");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle quality filter testbench
// Drives triangle beats through the filter under several register settings.
// A directed table covers index rejects, degenerate and extreme triangles.
// Random meshes with random idling and back-pressure follow. Every result
// beat is checked against its table verdict or an in-bench fixed point model.
// ----------------------------------------------------------------------------
module testbench;
    import tqf_pkg::*;

    localparam int MAX_IDLE  = 5000;
    localparam int DRAIN_CYC = 70;
    localparam int MAX_MISS  = 10;

    typedef struct packed {
        logic         keep;
        logic [31:0]  area;
        reject_code_t code;
    } verdict_t;

    typedef struct {
        logic [IN_DATA_W-1:0] data;
        bit                   typed;
        verdict_t             verdict;
    } stim_row_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]        cfg_data;

    // register shadow
    logic [16:0] vcount_sh;
    logic [31:0] min_area_sh, max_edge_sh, max_aspect_sh;
    logic [15:0] area_eps_sh, len_eps_sh;

    verdict_t  verdict_q[$];
    stim_row_t dir_rows[$];
    int        mismatches;
    int        idle_cycles;
    bit        quiet;
    bit        hold_req;
    int        hold_cnt;

    triangle_quality_filter i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    function automatic logic [191:0] magnitude(logic signed [95:0] x);
        logic signed [95:0] m;
        m = (x < 0) ? -x : x;
        magnitude = 192'(m);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [191:0] a);
        logic [63:0]  r;
        logic [191:0] c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = 192'(r | (64'd1 << b));
            if (c * c <= a) r = c[63:0];
        end
        int_sqrt = r;
    endfunction

    function automatic logic [63:0] edge_length(logic signed [95:0] dx,
                                                logic signed [95:0] dy,
                                                logic signed [95:0] dz);
        logic [191:0] mx, my, mz;
        mx = magnitude(dx);
        my = magnitude(dy);
        mz = magnitude(dz);
        edge_length = int_sqrt(mx * mx + my * my + mz * mz);
    endfunction

    function automatic verdict_t grade_triangle(logic [IN_DATA_W-1:0] d);
        logic [15:0]        ia, ib, ic;
        logic signed [95:0] p[9];
        logic signed [95:0] u[3], v[3];
        logic [191:0]       k0, k1, k2, n2;
        logic [63:0]        area, e0, e1, e2, emax, per;
        logic [191:0]       twa, epsp, lhs, rhs, a192, p192;
        reject_code_t       code;
        verdict_t           r;
        ia = d[15:0];
        ib = d[31:16];
        ic = d[47:32];
        for (int i = 0; i < 9; i++) p[i] = $signed(d[48 + 32 * i +: 32]);
        for (int i = 0; i < 3; i++) begin
            u[i] = p[3 + i] - p[i];
            v[i] = p[6 + i] - p[i];
        end
        k0 = magnitude(u[1] * v[2] - u[2] * v[1]);
        k1 = magnitude(u[2] * v[0] - u[0] * v[2]);
        k2 = magnitude(u[0] * v[1] - u[1] * v[0]);
        n2 = k0 * k0 + k1 * k1 + k2 * k2;
        area = int_sqrt(n2 >> 34);
        e0 = edge_length(p[0] - p[3], p[1] - p[4], p[2] - p[5]);
        e1 = edge_length(p[3] - p[6], p[4] - p[7], p[5] - p[8]);
        e2 = edge_length(p[6] - p[0], p[7] - p[1], p[8] - p[2]);
        emax = e0;
        if (e1 > emax) emax = e1;
        if (e2 > emax) emax = e2;
        per = e0 + e1 + e2;
        a192 = 192'(area);
        p192 = 192'(per);
        twa  = a192 << 17;
        epsp = 192'(len_eps_sh) * p192;
        lhs  = 192'(emax) * p192;
        rhs  = a192 * 192'(4) * 192'(max_aspect_sh);
        code = RC_KEEP;
        if (17'(ia) >= vcount_sh || 17'(ib) >= vcount_sh || 17'(ic) >= vcount_sh)
            code = RC_INDEX;
        else if (ia == ib || ib == ic || ia == ic)
            code = RC_REPEAT;
        else if (area <= 64'(area_eps_sh))
            code = RC_DEGEN;
        else if (min_area_sh != 0 && area < 64'(min_area_sh))
            code = RC_SMALL;
        else if (e0 <= 64'(len_eps_sh) || e1 <= 64'(len_eps_sh) || e2 <= 64'(len_eps_sh))
            code = RC_SHORT;
        else if (max_edge_sh != 0 && emax > 64'(max_edge_sh))
            code = RC_LONG;
        else if (max_aspect_sh != 0 && (twa <= epsp || lhs > rhs))
            code = RC_ASPECT;
        r.keep = (code == RC_KEEP);
        r.area = (area > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : area[31:0];
        r.code = code;
        grade_triangle = r;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_tri(logic [15:0] ia, logic [15:0] ib,
                                                      logic [15:0] ic, int c[9]);
        logic [IN_DATA_W-1:0] d;
        d = '0;
        d[15:0]  = ia;
        d[31:16] = ib;
        d[47:32] = ic;
        for (int i = 0; i < 9; i++) d[48 + 32 * i +: 32] = c[i];
        pack_tri = d;
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_tri();
        logic [15:0] ia, ib, ic;
        int          c[9];
        int          base, sel;
        if (vcount_sh >= 3 && $urandom_range(0, 9) < 8) begin
            ia = 16'($urandom_range(0, 32'(vcount_sh) - 1));
            do ib = 16'($urandom_range(0, 32'(vcount_sh) - 1)); while (ib == ia);
            do ic = 16'($urandom_range(0, 32'(vcount_sh) - 1));
            while (ic == ia || ic == ib);
        end else begin
            ia = 16'($urandom);
            ib = ($urandom_range(0, 3) == 0) ? ia : 16'($urandom);
            ic = 16'($urandom);
        end
        sel = $urandom_range(0, 9);
        for (int j = 0; j < 3; j++) begin
            base = (sel == 0) ? int'($urandom) : int'($urandom) >>> $urandom_range(0, 31);
            c[j] = base;
            c[3 + j] = base + (int'($urandom) >>> $urandom_range(0, 31));
            c[6 + j] = base + (int'($urandom) >>> $urandom_range(0, 31));
        end
        // degenerate shapes: repeated vertex, collinear vertex
        if (sel == 1) for (int j = 0; j < 3; j++) c[6 + j] = c[j];
        if (sel == 2) for (int j = 0; j < 3; j++) c[6 + j] = 2 * c[3 + j] - c[j];
        random_tri = pack_tri(ia, ib, ic, c);
    endfunction

    task automatic write_reg(cfg_index_t idx, logic [31:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_VERTEX_COUNT: vcount_sh     = value[16:0];
            CFG_MIN_AREA:     min_area_sh   = value;
            CFG_MAX_EDGE:     max_edge_sh   = value;
            CFG_MAX_ASPECT:   max_aspect_sh = value;
            CFG_AREA_EPS:     area_eps_sh   = value[15:0];
            CFG_LENGTH_EPS:   len_eps_sh    = value[15:0];
            default: ;
        endcase
    endtask

    task automatic load_limits(logic [31:0] vc, logic [31:0] amin, logic [31:0] emx,
                               logic [31:0] asp, logic [31:0] aeps, logic [31:0] leps);
        write_reg(CFG_VERTEX_COUNT, vc);
        write_reg(CFG_MIN_AREA, amin);
        write_reg(CFG_MAX_EDGE, emx);
        write_reg(CFG_MAX_ASPECT, asp);
        write_reg(CFG_AREA_EPS, aeps);
        write_reg(CFG_LENGTH_EPS, leps);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_empty();
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    task automatic send_tri(logic [IN_DATA_W-1:0] d, bit typed, verdict_t v);
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 99) < 18) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        verdict_q.insert(verdict_q.size(), typed ? v : grade_triangle(d));
    endtask

    task automatic run_random(int count);
        verdict_t none;
        none = '0;
        for (int n = 0; n < count; n++) send_tri(random_tri(), 1'b0, none);
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic add_row(logic [15:0] ia, logic [15:0] ib, logic [15:0] ic, int c[9],
                           bit typed, reject_code_t code);
        stim_row_t r;
        r.data    = pack_tri(ia, ib, ic, c);
        r.typed   = typed;
        r.verdict = '{keep: 1'b0, area: 32'd0, code: code};
        dir_rows.insert(dir_rows.size(), r);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt <= 400;
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet || ($urandom_range(0, 99) >= 18);
        end
    end

    always @(posedge aclk) begin
        verdict_t got, want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= MAX_IDLE) begin
                $display("CHECKS FAILED");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                got.keep = m_tdata[0];
                got.area = m_tdata[32:1];
                got.code = reject_code_t'(m_tdata[35:33]);
                if (verdict_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_MISS)
                        $display("unexpected result beat: %h", m_tdata);
                end else begin
                    want = verdict_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_MISS)
                            $display("mismatch: keep %0d/%0d area %h/%h code %0d/%0d",
                                     want.keep, got.keep, want.area, got.area,
                                     want.code, got.code);
                    end
                end
            end
        end
    end

    initial begin
        int z[9], c[9];
        mismatches  = 0;
        idle_cycles = 0;
        quiet       = 1'b0;
        hold_req    = 1'b0;
        hold_cnt    = 0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        m_tready    = 1'b0;
        vcount_sh = 0; min_area_sh = 0; max_edge_sh = 0;
        max_aspect_sh = 0; area_eps_sh = 0; len_eps_sh = 0;

        z = '{default: 0};
        add_row(0, 1, 2, z, 1'b1, RC_INDEX);          // vertex count still zero
        add_row(16, 1, 2, z, 1'b1, RC_INDEX);
        add_row(16'hFFFF, 1, 2, z, 1'b1, RC_INDEX);
        add_row(3, 3, 4, z, 1'b1, RC_REPEAT);
        add_row(5, 6, 6, z, 1'b1, RC_REPEAT);
        add_row(1, 2, 3, z, 1'b1, RC_DEGEN);
        c = '{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0};
        add_row(15, 14, 13, c, 1'b0, RC_KEEP);
        c = '{0, 0, 0, 32'h4000, 0, 0, 0, 32'h4000, 0};
        add_row(0, 1, 2, c, 1'b0, RC_KEEP);
        c = '{0, 0, 0, 32'h10000, 0, 0, 32'h10000, 32'h8, 32'h10000};
        add_row(0, 1, 2, c, 1'b0, RC_KEEP);
        c = '{0, 0, 0, 200 << 16, 0, 0, 0, 200 << 16, 0};
        add_row(0, 1, 2, c, 1'b0, RC_KEEP);
        c = '{0, 0, 0, 50 << 16, 0, 0, 25 << 16, 1 << 16, 0};
        add_row(0, 1, 2, c, 1'b0, RC_KEEP);
        c = '{0, 0, 0, 1 << 16, 1 << 16, 1 << 16, 2 << 16, 2 << 16, 2 << 16};
        add_row(0, 1, 2, c, 1'b0, RC_KEEP);
        c = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
              32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF};
        add_row(0, 1, 2, c, 1'b0, RC_KEEP);
        c = '{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
              32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF};
        add_row(15, 0, 7, c, 1'b0, RC_KEEP);
        c = '{-5 << 16, 3 << 16, -1, 4 << 16, -2 << 16, 1, -1 << 16, 6 << 16, 7};
        add_row(9, 10, 11, c, 1'b0, RC_KEEP);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < dir_rows.size(); i++) begin
            if (i == 1) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                wait_empty();
                load_limits(16, 32'h8000, 100 << 16, 10 << 16, 32'h10, 32'h10);
            end
            send_tri(dir_rows[i].data, dir_rows[i].typed, dir_rows[i].verdict);
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        wait_empty();
        load_limits(65536, 32'h100, 0, 20 << 16, 32'h40, 32'h40);
        hold_req = 1'b1;                      // let the pipeline fill and stall
        run_random(110);

        wait_empty();
        load_limits(1000, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFF, 32'hFFFF);
        quiet = 1'b1;
        run_random(105);
        quiet = 1'b0;

        wait_empty();
        load_limits(3, 0, 50 << 16, 2 << 16, 0, 0);
        run_random(105);

        wait_empty();
        load_limits(0, $urandom, $urandom, $urandom, $urandom, $urandom);
        run_random(30);

        for (int ph = 0; ph < 3; ph++) begin
            wait_empty();
            load_limits($urandom_range(3, 65536), $urandom >> $urandom_range(0, 31),
                        $urandom >> $urandom_range(0, 31), $urandom >> $urandom_range(0, 31),
                        $urandom_range(0, 65535) >> $urandom_range(0, 15),
                        $urandom_range(0, 65535) >> $urandom_range(0, 15));
            run_random(100);
        end

        wait_empty();
        if (verdict_q.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/tqf_pkg.sv
rtl/triangle_quality_filter.sv
verif/testbench.sv
